### hw/rtl/mltc_pkg.sv
// Shared types and constants of the motion light timer controller.
// Used by every module of the block; depends on nothing else.
package mltc_pkg;

    localparam int CFG_WIDTH          = 20;
    localparam int OUT_SEC_WIDTH      = 20;
    localparam int SECONDS_WIDTH_DEF  = 20;
    localparam int DELAY_WIDTH        = 8;
    localparam int APB_ADDR_WIDTH     = 4;
    localparam int APB_DATA_WIDTH     = 32;
    localparam int IN_TDATA_WIDTH     = 8;
    localparam int IN_TUSER_WIDTH     = 2;
    localparam int OUT_TDATA_WIDTH    = 32;

    localparam logic [DELAY_WIDTH-1:0] POWER_ON_DELAY_TICKS = 8'd20;

    localparam logic [CFG_WIDTH-1:0] NORMAL_ON_RESET      = 20'd300;
    localparam logic [CFG_WIDTH-1:0] REQUEST_ON_RESET     = 20'd60;
    localparam logic [CFG_WIDTH-1:0] REQUEST_WINDOW_RESET = 20'd600;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_NORMAL_ON      = 2'd0;
    localparam logic [1:0] REG_REQUEST_ON     = 2'd1;
    localparam logic [1:0] REG_REQUEST_WINDOW = 2'd2;

    typedef enum logic [1:0] {
        MODE_STAB    = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_MOTION  = 2'd2,
        MODE_REQUEST = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REQ_MOTION    = 2'd0,
        REQ_BUTTON    = 2'd1,
        REQ_STAB_TICK = 2'd2,
        REQ_SEC_TICK  = 2'd3
    } t_req;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] normal_on_seconds;
        logic [CFG_WIDTH-1:0] request_on_seconds;
        logic [CFG_WIDTH-1:0] request_window_seconds;
    } t_cfg;

    typedef struct packed {
        t_req req_type;
        logic has_motion;
        logic short_press;
        logic sensor_ready;
    } t_item;

    typedef struct packed {
        logic                     relay_on;
        logic                     request_indicator;
        logic                     running_indicator;
        t_mode                    mode_now;
        logic [OUT_SEC_WIDTH-1:0] seconds_left;
    } t_result;

endpackage

### hw/rtl/mltc_cfg_regs.sv
// Configuration register file of the motion light timer controller, on an APB-style port.
// Depends on mltc_pkg.
module mltc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mltc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [mltc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [mltc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output mltc_pkg::t_cfg                      o_cfg
);

    mltc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_on_seconds      <= mltc_pkg::NORMAL_ON_RESET;
            r_cfg.request_on_seconds     <= mltc_pkg::REQUEST_ON_RESET;
            r_cfg.request_window_seconds <= mltc_pkg::REQUEST_WINDOW_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                mltc_pkg::REG_NORMAL_ON: begin
                    r_cfg.normal_on_seconds <= pwdata[mltc_pkg::CFG_WIDTH-1:0];
                end
                mltc_pkg::REG_REQUEST_ON: begin
                    r_cfg.request_on_seconds <= pwdata[mltc_pkg::CFG_WIDTH-1:0];
                end
                mltc_pkg::REG_REQUEST_WINDOW: begin
                    r_cfg.request_window_seconds <= pwdata[mltc_pkg::CFG_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mltc_pkg::REG_NORMAL_ON: begin
                prdata = mltc_pkg::APB_DATA_WIDTH'(r_cfg.normal_on_seconds);
            end
            mltc_pkg::REG_REQUEST_ON: begin
                prdata = mltc_pkg::APB_DATA_WIDTH'(r_cfg.request_on_seconds);
            end
            mltc_pkg::REG_REQUEST_WINDOW: begin
                prdata = mltc_pkg::APB_DATA_WIDTH'(r_cfg.request_window_seconds);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/mltc_fsm.sv
// Mode state machine and countdowns of the motion light timer controller.
// Depends on mltc_pkg; the result shows the state after the item's update.
module mltc_fsm #(
    parameter int SECONDS_WIDTH = mltc_pkg::SECONDS_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mltc_pkg::t_item  i_item,
    input  mltc_pkg::t_cfg   i_cfg,
    output mltc_pkg::t_result o_result
);

    localparam int ExtW = (SECONDS_WIDTH > mltc_pkg::CFG_WIDTH) ?
                          SECONDS_WIDTH : mltc_pkg::CFG_WIDTH;
    localparam logic [SECONDS_WIDTH-1:0] SecOne = SECONDS_WIDTH'(1);

    mltc_pkg::t_mode                      r_mode, n_mode;
    logic [mltc_pkg::DELAY_WIDTH-1:0]     r_delay, n_delay;
    logic [SECONDS_WIDTH-1:0]             r_off, n_off;
    logic [SECONDS_WIDTH-1:0]             r_reqcd, n_reqcd;
    logic                                 r_relay, n_relay;
    logic                                 r_req_shown, n_req_shown;
    logic                                 r_run_shown, n_run_shown;

    logic [ExtW-1:0]          normal_ext, request_ext, window_ext, off_ext;
    logic [SECONDS_WIDTH-1:0] normal_on, request_on, window_len;

    // Register values brought to the countdown width.
    assign normal_ext  = ExtW'(i_cfg.normal_on_seconds);
    assign request_ext = ExtW'(i_cfg.request_on_seconds);
    assign window_ext  = ExtW'(i_cfg.request_window_seconds);
    assign normal_on   = normal_ext[SECONDS_WIDTH-1:0];
    assign request_on  = request_ext[SECONDS_WIDTH-1:0];
    assign window_len  = window_ext[SECONDS_WIDTH-1:0];

    // Next state. Later assignments override earlier ones, following the
    // order in which the actions of one event take effect.
    always_comb begin
        n_mode      = r_mode;
        n_delay     = r_delay;
        n_off       = r_off;
        n_reqcd     = r_reqcd;
        n_relay     = r_relay;
        n_req_shown = r_req_shown;
        n_run_shown = r_run_shown;
        unique case (i_item.req_type)
            mltc_pkg::REQ_MOTION: begin
                if (i_item.has_motion) begin
                    if (r_mode == mltc_pkg::MODE_IDLE) begin
                        n_mode  = mltc_pkg::MODE_MOTION;
                        n_off   = normal_on;
                        n_relay = 1'b1;
                    end else if (r_mode == mltc_pkg::MODE_MOTION) begin
                        n_off = normal_on;
                    end else if (r_mode == mltc_pkg::MODE_REQUEST) begin
                        n_off = request_on;
                    end
                end
            end
            mltc_pkg::REQ_BUTTON: begin
                if (i_item.short_press) begin
                    if (r_mode == mltc_pkg::MODE_IDLE) begin
                        n_mode  = mltc_pkg::MODE_MOTION;
                        n_off   = normal_on;
                        n_relay = 1'b1;
                    end else if (r_mode == mltc_pkg::MODE_MOTION) begin
                        n_mode      = mltc_pkg::MODE_REQUEST;
                        n_off       = request_on;
                        n_reqcd     = window_len;
                        n_req_shown = 1'b1;
                    end
                end
            end
            mltc_pkg::REQ_STAB_TICK: begin
                if (r_mode == mltc_pkg::MODE_STAB) begin
                    if (r_delay != '0) begin
                        n_delay = r_delay - 1'b1;
                        if (r_delay == mltc_pkg::DELAY_WIDTH'(1)) begin
                            n_relay = 1'b1;
                        end
                    end else if (i_item.sensor_ready) begin
                        n_run_shown = 1'b1;
                        n_mode      = mltc_pkg::MODE_MOTION;
                        n_off       = normal_on;
                        n_relay     = 1'b1;
                    end
                end
            end
            mltc_pkg::REQ_SEC_TICK: begin
                if (r_mode == mltc_pkg::MODE_MOTION || r_mode == mltc_pkg::MODE_REQUEST) begin
                    if (i_item.has_motion) begin
                        n_off = (r_mode == mltc_pkg::MODE_REQUEST) ? request_on : normal_on;
                    end else if (r_off <= SecOne) begin
                        // Off countdown expired: light off, request cancelled.
                        n_off       = '0;
                        n_mode      = mltc_pkg::MODE_IDLE;
                        n_relay     = 1'b0;
                        n_req_shown = 1'b0;
                    end else begin
                        n_off = r_off - 1'b1;
                    end
                end
                // The request window only advances while still in off request.
                if (n_mode == mltc_pkg::MODE_REQUEST) begin
                    if (r_reqcd <= SecOne) begin
                        n_reqcd     = '0;
                        n_mode      = mltc_pkg::MODE_MOTION;
                        n_off       = normal_on;
                        n_req_shown = 1'b0;
                    end else begin
                        n_reqcd = r_reqcd - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= mltc_pkg::MODE_STAB;
            r_delay     <= mltc_pkg::POWER_ON_DELAY_TICKS;
            r_off       <= '0;
            r_reqcd     <= '0;
            r_relay     <= 1'b0;
            r_req_shown <= 1'b0;
            r_run_shown <= 1'b0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_delay     <= n_delay;
            r_off       <= n_off;
            r_reqcd     <= n_reqcd;
            r_relay     <= n_relay;
            r_req_shown <= n_req_shown;
            r_run_shown <= n_run_shown;
        end
    end

    // Outputs: the state as it stands after this item.
    always_comb begin
        off_ext                    = ExtW'(n_off);
        o_result.relay_on          = n_relay;
        o_result.request_indicator = n_req_shown;
        o_result.running_indicator = n_run_shown;
        o_result.mode_now          = n_mode;
        o_result.seconds_left      = off_ext[mltc_pkg::OUT_SEC_WIDTH-1:0];
    end

endmodule

### hw/rtl/motion_light_timer_controller.sv
// Motion light timer controller: top level with input and result registers.
// Depends on mltc_pkg, mltc_cfg_regs and mltc_fsm.
//
// Each event transfer on the slave side yields exactly one result transfer on the
// master side, carrying relay drive, indicators, mode and the off countdown as they
// stand after the event. An event passes through an input register and then a result
// register, where its result is offered; a new event can be taken in every cycle
// while the master side keeps up. The rate is set by the combinational mode and
// countdown update between the two registers. The three timing registers are written
// over the APB-style port; the user must write them only while no event is in flight,
// as the block itself does not enforce this.
module motion_light_timer_controller #(
    parameter int SECONDS_WIDTH = mltc_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] has_motion, [1] short_press, [2] sensor_ready, [7:3] zero
    input  logic [mltc_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [mltc_pkg::IN_TUSER_WIDTH-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] relay_on, [1] request_indicator, [2] running_indicator,
    // [4:3] mode_now, [24:5] seconds_left, [31:25] zero
    output logic [mltc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mltc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [mltc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [mltc_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready
);

    mltc_pkg::t_cfg    cfg;
    mltc_pkg::t_item   in_item;
    mltc_pkg::t_result result;

    logic              r_in_valid;
    mltc_pkg::t_item   r_in_item;
    logic              r_out_valid;
    mltc_pkg::t_result r_out_result;
    logic              step;
    logic              in_xfer;

    mltc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mltc_fsm #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign in_item.req_type     = mltc_pkg::t_req'(s_axis_tuser);
    assign in_item.has_motion   = s_axis_tdata[0];
    assign in_item.short_press  = s_axis_tdata[1];
    assign in_item.sensor_ready = s_axis_tdata[2];

    // The held event is processed once the result register is free or being emptied.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= in_item;
        end
        if (step) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_out_result.seconds_left,
                            r_out_result.mode_now,
                            r_out_result.running_indicator,
                            r_out_result.request_indicator,
                            r_out_result.relay_on};

endmodule
